// File: sv/stok_pkg.sv
// Shared types, constants and character helpers for the source tokenizer.
`default_nettype none

package stok_pkg;

    // Internal counter widths
    localparam int POS_BITS  = 24;
    localparam int LINE_BITS = 16;

    // Field widths of a token record
    localparam int KIND_W = 6;
    localparam int LINE_W = 16;
    localparam int OFS_W  = 24;
    localparam int LEN_W  = 16;

    localparam int NKW = 16;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_PLUS   = 6'd12;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 6'd13;
    localparam logic [KIND_W-1:0] KIND_STAR   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_DIV    = 6'd15;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 6'd16;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 6'd17;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 6'd18;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 6'd19;
    localparam logic [KIND_W-1:0] KIND_LBRACK = 6'd20;
    localparam logic [KIND_W-1:0] KIND_RBRACK = 6'd21;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 6'd22;
    localparam logic [KIND_W-1:0] KIND_COLON  = 6'd23;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 6'd24;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd29;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd30;
    localparam logic [KIND_W-1:0] KIND_STRING = 6'd31;
    localparam logic [KIND_W-1:0] KIND_END    = 6'd32;
    localparam logic [KIND_W-1:0] KIND_NONE   = 6'd63;

    // Input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Keyword text, right aligned: character i of a word of length L sits in byte L-1-i
    localparam logic [63:0] KW_TEXT [NKW] = '{
        "let", "const", "var", "tensor", "matrix", "vector", "number", "model",
        "layer", "train", "test", "optimize", "if", "else", "for", "while"
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd3, 4'd5, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5,
        4'd5, 4'd5, 4'd4, 4'd8, 4'd2, 4'd4, 4'd3, 4'd5
    };
    localparam logic [KIND_W-1:0] KW_KIND [NKW] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
        6'd8, 6'd9, 6'd10, 6'd11, 6'd25, 6'd26, 6'd27, 6'd28
    };

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_NUM     = 6'b000010,
        MODE_IDENT   = 6'b000100,
        MODE_STR     = 6'b001000,
        MODE_SLASH   = 6'b010000,
        MODE_COMMENT = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [OFS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              last;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h3B:   k = KIND_SEMI;
            8'h3A:   k = KIND_COLON;
            8'h2C:   k = KIND_COMMA;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Keywords whose character at position len equals c
    function automatic logic [NKW-1:0] kw_hits(input logic [LEN_W-1:0] len,
                                               input logic [7:0] c);
        logic [NKW-1:0] h;
        logic [2:0]     b;
        h = '0;
        for (int k = 0; k < NKW; k++) begin
            if (len < LEN_W'(KW_LEN[k])) begin
                b    = 3'(KW_LEN[k] - 4'd1 - len[3:0]);
                h[k] = (KW_TEXT[k][{b, 3'b000} +: 8] == c);
            end
        end
        return h;
    endfunction

    function automatic logic [KIND_W-1:0] ident_kind(input logic [NKW-1:0] mask,
                                                     input logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        for (int i = NKW - 1; i >= 0; i--) begin
            if (mask[i] && (len == LEN_W'(KW_LEN[i])))
                k = KW_KIND[i];
        end
        return k;
    endfunction

    function automatic logic [LINE_W-1:0] to_line(input logic [LINE_BITS-1:0] v);
        return LINE_W'(64'(v));
    endfunction

    function automatic logic [OFS_W-1:0] to_ofs(input logic [POS_BITS-1:0] v);
        return OFS_W'(64'(v));
    endfunction

endpackage

`default_nettype wire

// File: sv/stok_front.sv
// Front end: accepts source bytes, runs the scanner and produces up to two token records.
`default_nettype none

module stok_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          cmd,
    input  wire logic [7:0]    ch,
    output stok_pkg::tok_t     wr_data0,
    output stok_pkg::tok_t     wr_data1,
    output logic [1:0]         wr_cnt
);

    localparam logic [stok_pkg::POS_BITS-1:0]  POS_MAX  = '1;
    localparam logic [stok_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [stok_pkg::LEN_W-1:0]     LEN_MAX  = '1;

    stok_pkg::mode_t                   mode_reg,  mode_next;
    logic [stok_pkg::POS_BITS-1:0]     start_reg, start_next;
    logic [stok_pkg::LEN_W-1:0]        len_reg,   len_next;
    logic [stok_pkg::LINE_BITS-1:0]    line_reg,  line_next;
    logic [stok_pkg::POS_BITS-1:0]     pos_reg,   pos_next;
    logic [stok_pkg::NKW-1:0]          mask_reg,  mask_next;

    logic                              flush_v, other_v, idle_scan;
    stok_pkg::tok_t                    flush_rec, other_rec;
    logic [stok_pkg::KIND_W-1:0]       pk;
    logic [stok_pkg::LINE_BITS-1:0]    line_inc;
    logic [stok_pkg::LEN_W-1:0]        len_inc;

    assign line_inc = (line_reg < LINE_MAX) ? line_reg + 1'b1 : line_reg;
    assign len_inc  = (len_reg < LEN_MAX) ? len_reg + 1'b1 : len_reg;
    assign pk       = stok_pkg::punct_kind(ch);

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        mask_next  = mask_reg;
        idle_scan  = 1'b0;
        other_v    = 1'b0;

        flush_rec.line  = stok_pkg::to_line(line_reg);
        flush_rec.start = stok_pkg::to_ofs(start_reg);
        flush_rec.len   = (mode_reg == stok_pkg::MODE_SLASH) ? stok_pkg::LEN_W'(1) : len_reg;
        flush_rec.last  = 1'b0;
        unique case (mode_reg)
            stok_pkg::MODE_NUM:   flush_rec.kind = stok_pkg::KIND_NUMBER;
            stok_pkg::MODE_IDENT: flush_rec.kind = stok_pkg::ident_kind(mask_reg, len_reg);
            default:              flush_rec.kind = stok_pkg::KIND_DIV;
        endcase
        flush_v = 1'b0;

        other_rec.kind  = pk;
        other_rec.line  = stok_pkg::to_line(line_reg);
        other_rec.start = stok_pkg::to_ofs(pos_reg);
        other_rec.len   = stok_pkg::LEN_W'(1);
        other_rec.last  = 1'b1;

        if (cmd == stok_pkg::CMD_END)
        begin
            flush_v = (mode_reg == stok_pkg::MODE_NUM) || (mode_reg == stok_pkg::MODE_IDENT)
                   || (mode_reg == stok_pkg::MODE_SLASH);
            other_v        = 1'b1;
            other_rec.kind = stok_pkg::KIND_END;
            other_rec.len  = '0;
            // start a fresh source
            mode_next  = stok_pkg::MODE_IDLE;
            start_next = '0;
            len_next   = '0;
            line_next  = stok_pkg::LINE_BITS'(1);
            pos_next   = '0;
            mask_next  = '1;
        end
        else
        begin
            unique case (mode_reg)
                stok_pkg::MODE_NUM:
                begin
                    if (stok_pkg::is_digit(ch))
                        len_next = len_inc;
                    else
                    begin
                        flush_v   = 1'b1;
                        idle_scan = 1'b1;
                    end
                end
                stok_pkg::MODE_IDENT:
                begin
                    if (stok_pkg::is_alpha(ch) || stok_pkg::is_digit(ch))
                    begin
                        mask_next = mask_reg & stok_pkg::kw_hits(len_reg, ch);
                        len_next  = len_inc;
                    end
                    else
                    begin
                        flush_v   = 1'b1;
                        idle_scan = 1'b1;
                    end
                end
                stok_pkg::MODE_SLASH:
                begin
                    if (ch == 8'h2F)
                        mode_next = stok_pkg::MODE_COMMENT;
                    else
                    begin
                        flush_v   = 1'b1;
                        idle_scan = 1'b1;
                    end
                end
                stok_pkg::MODE_COMMENT:
                begin
                    if (ch == 8'h0A)
                    begin
                        line_next = line_inc;
                        mode_next = stok_pkg::MODE_IDLE;
                    end
                end
                stok_pkg::MODE_STR:
                begin
                    len_next = len_inc;
                    if (ch == 8'h0A)
                        line_next = line_inc;
                    if (ch == 8'h22)
                    begin
                        other_v         = 1'b1;
                        other_rec.kind  = stok_pkg::KIND_STRING;
                        other_rec.start = stok_pkg::to_ofs(start_reg);
                        other_rec.len   = len_inc;
                        mode_next       = stok_pkg::MODE_IDLE;
                    end
                end
                default:
                    idle_scan = 1'b1;
            endcase

            if (idle_scan)
            begin
                mode_next = stok_pkg::MODE_IDLE;
                if (pk != stok_pkg::KIND_NONE)
                    other_v = 1'b1;
                else if (ch == 8'h0A)
                    line_next = line_inc;
                else if (ch == 8'h2F || ch == 8'h22 || stok_pkg::is_digit(ch)
                         || stok_pkg::is_alpha(ch))
                begin
                    start_next = pos_reg;
                    len_next   = stok_pkg::LEN_W'(1);
                    if (ch == 8'h2F)
                        mode_next = stok_pkg::MODE_SLASH;
                    else if (ch == 8'h22)
                        mode_next = stok_pkg::MODE_STR;
                    else if (stok_pkg::is_digit(ch))
                        mode_next = stok_pkg::MODE_NUM;
                    else
                    begin
                        mode_next = stok_pkg::MODE_IDENT;
                        mask_next = stok_pkg::kw_hits('0, ch);
                    end
                end
            end
        end
    end

    // Pending token goes first; the record that comes with this byte follows
    always_comb
    begin
        wr_data0      = flush_v ? flush_rec : other_rec;
        wr_data0.last = !(flush_v && other_v);
        wr_data1      = other_rec;
        wr_cnt        = accept ? (2'(flush_v) + 2'(other_v)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stok_pkg::MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            line_reg  <= stok_pkg::LINE_BITS'(1);
            pos_reg   <= '0;
            mask_reg  <= '1;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            mask_reg  <= mask_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/stok_queue.sv
// Record queue between scanner and output stage: up to two writes and one read per cycle.
`default_nettype none

module stok_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    wr_cnt,
    input  stok_pkg::tok_t     wr_data0,
    input  stok_pkg::tok_t     wr_data1,
    output logic               space,
    output logic               rd_valid,
    output stok_pkg::tok_t     rd_data,
    input  wire logic          rd_take
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    stok_pkg::tok_t   mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg,  count_next;
    logic [AW-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    // hold off the scanner unless a two-record byte would fit
    assign space    = (count_reg <= (AW+1)'(DEPTH - 2));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + AW'(rd_take);
        count_next  = count_reg + (AW+1)'(wr_cnt) - (AW+1)'(rd_take);
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= wr_data0;
        if (wr_cnt == 2'd2)
            mem_reg[wr_ptr_plus1] <= wr_data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/stok_back.sv
// Output stage: registers one token record and holds it until the transfer completes.
`default_nettype none

module stok_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_valid,
    input  stok_pkg::tok_t     rd_data,
    output logic               rd_take,
    output logic               out_valid,
    input  wire logic          out_stall,
    output stok_pkg::tok_t     out_data
);

    logic            valid_reg, valid_next;
    stok_pkg::tok_t  data_reg;

    assign rd_take    = rd_valid && (!valid_reg || !out_stall);
    assign valid_next = rd_take || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_take)
            data_reg <= rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

`default_nettype wire

// File: sv/source_tokenizer.sv
// Top level of the source tokenizer: scanner front end, record queue and output stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, ch
//  out     | output    | out_valid / out_stall| token_kind, line_number, start_offset,
//          |           |                      | token_length, last_of_run
//
// One source byte is taken per cycle while in_stall is low; the scanner state updates
// in that cycle. A byte yields up to two records; the four-entry queue drains one
// record per cycle while out_stall is low, so two-record bytes fill the queue.
// The first record enters the queue with its byte, then the output stage register.
// in_stall rises when the queue has fewer than two free entries.
// rst_n clears scanner state to line 1, offset 0, and empties queue and output stage.
`default_nettype none

module source_tokenizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [7:0]                    ch,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [stok_pkg::KIND_W-1:0]        token_kind,
    output logic [stok_pkg::LINE_W-1:0]        line_number,
    output logic [stok_pkg::OFS_W-1:0]         start_offset,
    output logic [stok_pkg::LEN_W-1:0]         token_length,
    output logic                               last_of_run
);

    logic            accept;
    logic            space;
    logic [1:0]      wr_cnt;
    stok_pkg::tok_t  wr_data0, wr_data1;
    logic            rd_valid, rd_take;
    stok_pkg::tok_t  rd_data, out_data;

    assign in_stall = !space;
    assign accept   = in_valid && space;

    stok_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .ch       (ch),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .wr_cnt   (wr_cnt)
    );

    stok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .space    (space),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rd_take  (rd_take)
    );

    stok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data),
        .rd_take   (rd_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign token_kind   = out_data.kind;
    assign line_number  = out_data.line;
    assign start_offset = out_data.start;
    assign token_length = out_data.len;
    assign last_of_run  = out_data.last;

endmodule

`default_nettype wire

// File: sv/stok_checker.sv
// Port-level checks on the source tokenizer, attached to the top level by bind.
`default_nettype none

module stok_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [stok_pkg::KIND_W-1:0]   token_kind,
    input wire logic [stok_pkg::LINE_W-1:0]   line_number,
    input wire logic [stok_pkg::OFS_W-1:0]    start_offset,
    input wire logic [stok_pkg::LEN_W-1:0]    token_length,
    input wire logic                          last_of_run
);

    // a stalled record stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind)
            && $stable(start_offset) && $stable(token_length) && $stable(last_of_run))
        else $error("stalled output record changed");

    // end-of-source record closes its run and has no lexeme
    a_end_rec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == stok_pkg::KIND_END) |-> last_of_run
            && (token_length == '0))
        else $error("end record malformed");

    // punctuation and operators are single characters
    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind >= stok_pkg::KIND_PLUS)
            && (token_kind <= stok_pkg::KIND_COMMA) |-> (token_length == 16'd1))
        else $error("punctuation record length not one");

    // line count never drops to zero and the kind never exceeds the end-of-source code
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_number != '0) && (token_kind <= stok_pkg::KIND_END))
        else $error("bad line number or kind");

    // the partner of a record that ends no run is already queued behind it
    a_run_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("run continuation broken");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

`default_nettype wire
